// ===== src/rhss_pkg.sv =====
// Package for the rolling-hash substring search block.
// Holds the hash constants, the register map, the phase type and the cell control struct.
// No dependencies.
package rhss_pkg;

  localparam int HashW = 15;
  localparam logic [HashW-1:0] HASH_BASE = 15'd1021;
  localparam int PatBytes = 16;
  localparam int LenW = 5;

  typedef enum logic [1:0] {
    REG_PAT_LO  = 2'd0,
    REG_PAT_HI  = 2'd1,
    REG_PAT_LEN = 2'd2
  } reg_idx_e;

  typedef enum logic {
    PH_PREP = 1'b0,
    PH_RUN  = 1'b1
  } phase_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== src/rhss_in_if.sv =====
// Text input channel: valid/ready handshake carrying one text byte and its end mark.
// No dependencies.
interface rhss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, text_byte, last_byte, input ready);
  modport sink   (input valid, text_byte, last_byte, output ready);
endinterface

// ===== src/rhss_out_if.sv =====
// Result channel: valid/ready handshake carrying the found flag and start position.
// No dependencies.
interface rhss_out_if #(
  parameter int POSITION_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [POSITION_BITS-1:0] match_position;

  modport source (output valid, found, match_position, input ready);
  modport sink   (input valid, found, match_position, output ready);
endinterface

// ===== src/rhss_cell.sv =====
// One window cell: holds one text byte, passes it to the next cell on a shift.
// Depends on rhss_pkg.
module rhss_cell
  import rhss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] pat_i,
  input  logic       active_i,
  output logic [7:0] byte_o,
  output logic       match_o
);

  logic [7:0] byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else if (ctrl_i.clear) begin
      byte_q <= '0;
    end else if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  // compares the byte this cell takes on the shift
  assign match_o = !active_i || (byte_i == pat_i);
  assign byte_o  = byte_q;

endmodule

// ===== src/rolling_hash_substring_search.sv =====
// Top level of the rolling-hash substring search: APB register file, pattern hash
// sequencer, hash update, and the row of window cells.
// Depends on rhss_pkg, rhss_in_if, rhss_out_if, rhss_cell.
//
//   channel  dir  handshake           payload
//   in_i     in   valid/ready         text_byte[7:0], last_byte
//   out_o    out  valid/ready         found, match_position[POSITION_BITS-1:0]
//   apb      in   psel/penable/pwrite paddr[4:0], pwdata[63:0], prdata[63:0]
//
// One byte per cycle once the pattern hash is ready; the hash and compare finish in the
// accepting cycle and a result is registered for the next.
// After reset and after each register write a pass computes the pattern hash and base
// power, one multiply-add step per cycle; no item is taken during it.
// A waiting result holds the input back only if it is not taken in the same cycle.
module rolling_hash_substring_search
  import rhss_pkg::*;
#(
  parameter int MAX_PATTERN   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rhss_in_if.sink      in_i,
  rhss_out_if.source   out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LenW-1:0] MaxK = LenW'(MAX_PATTERN);
  localparam logic [POSITION_BITS:0] CountCap = {1'b1, POSITION_BITS'(MAX_PATTERN)};

  // registers
  logic [63:0]     pat_lo_q, pat_hi_q;
  logic [LenW-1:0] pat_len_q;
  logic            cfg_wr, cfg_hit;
  reg_idx_e        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_hit = 1'b0;
    prdata  = '0;
    case (reg_idx)
      REG_PAT_LO: begin
        cfg_hit = cfg_wr;
        prdata  = pat_lo_q;
      end
      REG_PAT_HI: begin
        cfg_hit = cfg_wr;
        prdata  = pat_hi_q;
      end
      REG_PAT_LEN: begin
        cfg_hit = cfg_wr;
        prdata  = 64'(pat_len_q);
      end
      default: begin
        cfg_hit = 1'b0;
        prdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_hi_q  <= '0;
      pat_len_q <= LenW'(1);
    end else if (cfg_hit) begin
      case (reg_idx)
        REG_PAT_LO:  pat_lo_q  <= pwdata;
        REG_PAT_HI:  pat_hi_q  <= pwdata;
        REG_PAT_LEN: pat_len_q <= pwdata[LenW-1:0];
        default:     pat_lo_q  <= pat_lo_q;
      endcase
    end
  end

  // effective length and pattern bytes
  logic [LenW-1:0] k;
  logic [7:0]      pat_b [PatBytes];

  always_comb begin
    if (pat_len_q == '0) begin
      k = LenW'(1);
    end else if (pat_len_q > MaxK) begin
      k = MaxK;
    end else begin
      k = pat_len_q;
    end
  end

  for (genvar j = 0; j < PatBytes; j++) begin : g_pat
    if (j < 8) begin : g_lo
      assign pat_b[j] = pat_lo_q[8*j +: 8];
    end else begin : g_hi
      assign pat_b[j] = pat_hi_q[8*(j-8) +: 8];
    end
  end

  // pattern hash sequencer
  phase_e          state_q, state_d;
  logic [LenW-1:0] seq_q;
  logic [HashW-1:0] phash_q, pw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_PREP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      PH_PREP: if (seq_q >= k) state_d = PH_RUN;
      PH_RUN:  state_d = PH_RUN;
      default: state_d = PH_PREP;
    endcase
    if (cfg_hit) state_d = PH_PREP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= '0;
      phash_q <= '0;
      pw_q    <= HashW'(1);
    end else if (cfg_hit) begin
      seq_q   <= '0;
      phash_q <= '0;
      pw_q    <= HashW'(1);
    end else if (state_q == PH_PREP && seq_q < k) begin
      seq_q   <= seq_q + LenW'(1);
      phash_q <= HashW'(phash_q * HASH_BASE) + HashW'(pat_b[seq_q[3:0]]);
      pw_q    <= HashW'(pw_q * HASH_BASE);
    end
  end

  // search state
  logic [HashW-1:0]       hash_q, hash_d;
  logic [POSITION_BITS:0] seen_q, seen_d, start;
  logic                   rep_q, hit, acc, last;
  logic [7:0]             lv;
  logic [7:0]             win   [MAX_PATTERN];
  logic [7:0]             prev  [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cmatch;
  cell_ctrl_t             cctl;

  logic                     out_valid_q, found_q;
  logic [POSITION_BITS-1:0] pos_q;

  assign in_i.ready = (state_q == PH_RUN) && (!out_valid_q || out_o.ready);
  assign acc        = in_i.valid && in_i.ready;
  assign last       = in_i.last_byte;

  assign cctl.clear = cfg_hit || (acc && last);
  assign cctl.shift = acc && !rep_q;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [LenW-1:0] pidx;
    assign pidx = k - LenW'(1) - LenW'(i);
    if (i == 0) begin : g_head
      assign prev[i] = in_i.text_byte;
    end else begin : g_link
      assign prev[i] = win[i-1];
    end
    rhss_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cctl),
      .byte_i   (prev[i]),
      .pat_i    (pat_b[pidx[3:0]]),
      .active_i (LenW'(i) < k),
      .byte_o   (win[i]),
      .match_o  (cmatch[i])
    );
  end

  always_comb begin
    logic [LenW-1:0] li;
    li     = k - LenW'(1);
    lv     = win[li[IdxW-1:0]];
    hash_d = HashW'(hash_q * HASH_BASE) - HashW'(lv * pw_q) + HashW'(in_i.text_byte);
    seen_d = (seen_q < CountCap) ? seen_q + 1'b1 : seen_q;
    start  = seen_d - (POSITION_BITS + 1)'(k);
    hit    = (seen_d >= (POSITION_BITS + 1)'(k)) && (hash_d == phash_q) && (&cmatch)
             && !start[POSITION_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
      seen_q <= '0;
      rep_q  <= 1'b0;
    end else if (cctl.clear) begin
      hash_q <= '0;
      seen_q <= '0;
      rep_q  <= 1'b0;
    end else if (cctl.shift) begin
      hash_q <= hash_d;
      seen_q <= seen_d;
      rep_q  <= hit;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc && !rep_q && (hit || last)) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !rep_q && (hit || last)) begin
      found_q <= hit;
      pos_q   <= hit ? start[POSITION_BITS-1:0] : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.found          = found_q;
  assign out_o.match_position = pos_q;

  // checks
  a_no_take_in_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == PH_PREP |-> !in_i.ready)
    else $error("item accepted during pattern hash pass");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && last |=> seen_q == '0 && !rep_q && hash_q == '0)
    else $error("search state not cleared after end of text");

  a_report_sets_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !rep_q && hit && !last && !cfg_hit |=> rep_q && out_valid_q && found_q)
    else $error("match reported without setting the reported flag");

  a_miss_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_q |-> pos_q == '0)
    else $error("not-found result with nonzero position");

endmodule
